/* rtl/core/swa_pkg.sv */
// Shared widths and default parameter values for the sliding window average block.
// No dependencies; used by the top level, the serial divider and the checker.
`default_nettype none

package swa_pkg;

  // Field widths of the stream items and of the configuration register.
  localparam int SAMPLE_W = 18;
  localparam int SUM_W    = 28;
  localparam int CNT_W    = 11;
  localparam int AVG_W    = 34;

  // Stream bus widths, padded to whole bytes.
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 80;

  // Bit positions of the result fields inside the master tdata.
  localparam int AVG_LSB = 0;
  localparam int SUM_LSB = AVG_LSB + AVG_W;
  localparam int CNT_LSB = SUM_LSB + SUM_W;
  localparam int PAD_LSB = CNT_LSB + CNT_W;

  // Defaults for the top level parameters.
  localparam int DEF_MAX_WINDOW = 1024;
  localparam int DEF_FRAC_BITS  = 16;

endpackage

`default_nettype wire

/* rtl/core/swa_div.sv */
// Bit-serial restoring divider: one quotient bit per clock cycle.
// Depends on swa_pkg for the divisor width.
`default_nettype none

module swa_div
  import swa_pkg::*;
#(
  parameter int DW = SUM_W + DEF_FRAC_BITS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DW-1:0]     dividend_i,
  input  wire logic [CNT_W-1:0]  divisor_i,
  output logic                   done_o,
  output logic [DW-1:0]          quotient_o
);

  localparam int CTW = $clog2(DW + 1);

  logic [DW-1:0]    quo_q;
  logic [CNT_W-1:0] rem_q;
  logic [CNT_W-1:0] dvs_q;
  logic [CTW-1:0]   cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [CNT_W:0]   part;
  logic [CNT_W:0]   trial;
  logic             qbit;

  // One trial subtraction: bring down the next dividend bit and compare.
  always_comb begin
    part  = {rem_q, quo_q[DW-1]};
    trial = part - {1'b0, dvs_q};
    qbit  = ~trial[CNT_W];
  end

  // Control: step counter, busy and completion flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CTW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CTW'(1);
        if (cnt_q == CTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend shifts out at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DW-2:0], qbit};
      rem_q <= qbit ? trial[CNT_W-1:0] : part[CNT_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

/* rtl/core/sliding_window_average_top.sv */
// Flow: an accepted sample is added to the running sum in the ST_SUM state, then divided by
// the fill count in ST_DIV by the bit-serial divider, which produces one quotient bit per cycle,
// and registered as the result in ST_OUT. A new sample is accepted only in ST_IDLE, once the
// result of the previous one has been registered; a result that waits holds the next one off.
// Reset: asynchronous, active low; window size one, window empty. The sample ring is not
// cleared, since an entry is only read after it has been written.
// Depends on swa_pkg and swa_div.
`default_nettype none

module sliding_window_average_top
  import swa_pkg::*;
#(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Sample stream. tdata: [17:0] sample, [23:18] zero.
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata_i,
  // Result stream. tdata: [33:0] average_fixed, [61:34] window_sum,
  // [72:62] fill_count, [79:73] zero.
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic [M_TDATA_W-1:0]       m_axis_tdata_o,
  // Window size register.
  input  wire logic                  cfg_we_i,
  input  wire logic [CNT_W-1:0]      cfg_wdata_i
);

  localparam int AW  = $clog2(MAX_WINDOW);
  localparam int CW  = ((AW > CNT_W) ? AW : CNT_W) + 1;
  localparam int DW  = SUM_W + FRAC_BITS;
  localparam int QX  = (DW > AVG_W) ? DW : AVG_W;
  localparam logic [QX-1:0] POS_MAX = QX'({1'b0, {(AVG_W-1){1'b1}}});
  localparam logic [QX-1:0] NEG_MAG = QX'({1'b1, {(AVG_W-1){1'b0}}});

  // Sequencer state codes.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [CNT_W-1:0]    win_q;
  logic [AW-1:0]       newest_q;
  logic [AW-1:0]       oldest_q;
  logic [CNT_W-1:0]    held_q;
  logic [SUM_W-1:0]    sum_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic                sub_q;
  logic                start_q;
  logic [SAMPLE_W-1:0] ring_rd_q;
  logic [SAMPLE_W-1:0] ring_mem [MAX_WINDOW];

  logic                m_valid_q;
  logic [AVG_W-1:0]    avg_q;
  logic [SUM_W-1:0]    out_sum_q;
  logic [CNT_W-1:0]    out_cnt_q;

  logic                in_acc;
  logic                full;
  logic [AW-1:0]       newest_nx;
  logic [AW-1:0]       oldest_nx;
  logic [CNT_W-1:0]    cfg_win;
  logic [SUM_W-1:0]    sum_d;
  logic [SUM_W-1:0]    sum_mag;
  logic [DW-1:0]       dividend;
  logic                div_done;
  logic [DW-1:0]       quotient;
  logic [QX-1:0]       q_x;
  logic [AVG_W-1:0]    mag_sat;
  logic [AVG_W-1:0]    avg_d;
  logic                out_free;

  // Advance a ring slot, wrapping at the effective window size.
  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] s,
                                              input logic [CNT_W-1:0] w);
    logic [CW-1:0] inc;
    inc = CW'(s) + CW'(1);
    return (inc >= CW'(w)) ? '0 : AW'(inc);
  endfunction

  // Effective window of a register write: zero acts as one, large values clamp.
  always_comb begin
    if (cfg_wdata_i == '0) begin
      cfg_win = CNT_W'(1);
    end else if (32'(cfg_wdata_i) > MAX_WINDOW) begin
      cfg_win = CNT_W'(MAX_WINDOW);
    end else begin
      cfg_win = cfg_wdata_i;
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign full            = (held_q >= win_q);
  assign newest_nx       = next_slot(newest_q, win_q);
  assign oldest_nx       = next_slot(oldest_q, win_q);
  assign out_free        = ~m_valid_q | m_axis_tready_i;

  // Ring store: the new sample is written and the oldest one read on acceptance.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ring_mem[newest_nx] <= s_axis_tdata_i[SAMPLE_W-1:0];
      ring_rd_q           <= ring_mem[oldest_q];
    end
  end

  // New running sum: add the sample, drop the oldest one when the window was full.
  always_comb begin
    sum_d = sum_q + {{(SUM_W-SAMPLE_W){sample_q[SAMPLE_W-1]}}, sample_q};
    if (sub_q) begin
      sum_d = sum_d - {{(SUM_W-SAMPLE_W){ring_rd_q[SAMPLE_W-1]}}, ring_rd_q};
    end
  end

  // Magnitude of the sum, scaled by the fraction bits, feeds the divider.
  assign sum_mag  = sum_q[SUM_W-1] ? (SUM_W'(0) - sum_q) : sum_q;
  assign dividend = DW'(sum_mag) << FRAC_BITS;

  swa_div #(
    .DW(DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .dividend_i (dividend),
    .divisor_i  (held_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Saturate the quotient magnitude and restore the sign.
  always_comb begin
    q_x = QX'(quotient);
    if (sum_q[SUM_W-1]) begin
      mag_sat = (q_x > NEG_MAG) ? AVG_W'(NEG_MAG) : AVG_W'(q_x);
      avg_d   = AVG_W'(0) - mag_sat;
    end else begin
      mag_sat = (q_x > POS_MAX) ? AVG_W'(POS_MAX) : AVG_W'(q_x);
      avg_d   = mag_sat;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_SUM;
      ST_SUM:  state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Window state, sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      win_q     <= CNT_W'(1);
      newest_q  <= '0;
      oldest_q  <= '0;
      held_q    <= '0;
      sum_q     <= '0;
      sub_q     <= 1'b0;
      start_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= (state_q == ST_SUM);
      if (state_q == ST_OUT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        win_q    <= cfg_win;
        newest_q <= AW'(cfg_win - CNT_W'(1));
        oldest_q <= '0;
        held_q   <= '0;
        sum_q    <= '0;
      end else if (in_acc) begin
        newest_q <= newest_nx;
        sub_q    <= full;
        if (full) begin
          oldest_q <= oldest_nx;
        end else begin
          held_q <= held_q + CNT_W'(1);
        end
      end else if (state_q == ST_SUM) begin
        sum_q <= sum_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= s_axis_tdata_i[SAMPLE_W-1:0];
    end
    if (state_q == ST_OUT && out_free) begin
      avg_q     <= avg_d;
      out_sum_q <= sum_q;
      out_cnt_q <= held_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(M_TDATA_W-PAD_LSB){1'b0}}, out_cnt_q, out_sum_q, avg_q};

endmodule

`default_nettype wire

/* rtl/core/swa_checker.sv */
// Port-level checks for the sliding window average top level, bound to it below.
// Depends on swa_pkg for the result field positions.
`default_nettype none

module swa_checker
  import swa_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_axis_tvalid_i,
  input wire logic                 s_axis_tready_o,
  input wire logic                 m_axis_tvalid_o,
  input wire logic                 m_axis_tready_i,
  input wire logic [M_TDATA_W-1:0] m_axis_tdata_o
);

  // A held result stays valid until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("result request dropped before it was taken");

  // One sample at a time: ready falls right after a sample request is accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("sample accepted while the previous one is still in work");

  // Every result covers at least one sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[CNT_LSB +: CNT_W] != '0))
    else $error("result with an empty window");

  // A zero sum always averages to zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tdata_o[SUM_LSB +: SUM_W] == '0))
      |-> (m_axis_tdata_o[AVG_LSB +: AVG_W] == '0))
    else $error("nonzero average for a zero sum");

endmodule

bind sliding_window_average_top swa_checker u_swa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
